// ===== design/srf_pkg.sv =====
`default_nettype none

package srf_pkg;

   localparam int CharWidth       = 8;
   localparam int PatLenWidth     = 4;
   localparam int PatCharsWidth   = 64;
   localparam int CsrIndexWidth   = 1;
   localparam int CsrDataWidth    = 64;

   // register map of the configuration port
   localparam logic [CsrIndexWidth-1:0] RegPatternLength = 1'd0;
   localparam logic [CsrIndexWidth-1:0] RegPatternChars  = 1'd1;

   // control handed from the window stage to the output buffer
   typedef struct packed {
      logic load;    // a byte was taken this cycle
      logic last;    // it was the final byte of the text
      logic marker;  // nothing kept, send a bare end marker
   } srf_load_type;

endpackage

`default_nettype wire

// ===== design/srf_req_if.sv =====
`default_nettype none

interface srf_req_if import srf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_in;
   logic                 last_in;

   modport source (output valid, char_in, last_in, input ready);
   modport sink (input valid, char_in, last_in, output ready);
endinterface

`default_nettype wire

// ===== design/srf_rsp_if.sv =====
`default_nettype none

interface srf_rsp_if import srf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_out;
   logic                 char_valid;
   logic                 last_out;

   modport source (output valid, char_out, char_valid, last_out, input ready);
   modport sink (input valid, char_out, char_valid, last_out, output ready);
endinterface

`default_nettype wire

// ===== design/srf_csr_if.sv =====
`default_nettype none

interface srf_csr_if import srf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/substring_removal_filter.sv =====
`default_nettype none

// substring removal filter: text bytes stream in on req_ch, one per
// transaction, and every non-overlapping occurrence of the configured pattern
// (pattern_length bytes of pattern_chars, byte 0 in the low bits) is removed,
// scanning left to right; the kept bytes leave on rsp_ch in order. last_in
// ends a text: the pending bytes are flushed and last_out marks the final
// response, which is a bare end marker (char_valid low) when no byte is left.
// a pattern length of zero passes bytes through, lengths above MAX_PATTERN
// count as MAX_PATTERN. configuration must be written on csr_ch (index 0 length,
// index 1 pattern bytes) only while the block is idle; the block itself does
// not enforce this. rate: one byte per clock whenever a byte releases at most
// one response and rsp_ch.ready is high; a byte that releases more responses
// (a flush at the end of text, or a shortened length) holds req_ch.ready low
// until the buffer is down to its last response, as the buffer drains one
// response per clock while rsp_ch.ready is high. no clearing pass after reset.
module substring_removal_filter import srf_pkg::*; #(
   parameter int MAX_PATTERN = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   srf_req_if.sink    req_ch,
   srf_rsp_if.source  rsp_ch,
   srf_csr_if.sink    csr_ch
);

   localparam int CountWidth = $clog2(MAX_PATTERN + 1);

   // configuration registers
   logic [PatLenWidth-1:0]   pattern_length_ff;
   logic [PatCharsWidth-1:0] pattern_chars_ff;

   logic                     accept;
   logic                     can_load;
   logic [CharWidth-1:0]     emit_bytes [MAX_PATTERN];
   logic [CountWidth-1:0]    emit_count;
   srf_load_type             emit_ctl;

   // csr writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_chars_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            RegPatternLength: pattern_length_ff <= csr_ch.data[PatLenWidth-1:0];
            RegPatternChars:  pattern_chars_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // a new byte enters once the buffer is empty or sends its last response
   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   // pending window, pattern compare and prefix selection
   srf_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .char_in        (req_ch.char_in),
      .last_in        (req_ch.last_in),
      .pattern_length (pattern_length_ff),
      .pattern_chars  (pattern_chars_ff),
      .emit_bytes     (emit_bytes),
      .emit_count     (emit_count),
      .emit_ctl       (emit_ctl)
   );

   // result register, drains kept bytes one per transaction
   srf_out_buf #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load_bytes (emit_bytes),
      .load_count (emit_count),
      .load_ctl   (emit_ctl),
      .can_load   (can_load),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .char_out   (rsp_ch.char_out),
      .char_valid (rsp_ch.char_valid),
      .last_out   (rsp_ch.last_out)
   );

endmodule

`default_nettype wire

// ===== design/srf_window.sv =====
`default_nettype none

module srf_window import srf_pkg::*; #(
   parameter  int MAX_PATTERN = 8,
   localparam int CountWidth  = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [CharWidth-1:0]     char_in,
   input  wire logic                     last_in,
   input  wire logic [PatLenWidth-1:0]   pattern_length,
   input  wire logic [PatCharsWidth-1:0] pattern_chars,
   output logic      [CharWidth-1:0]     emit_bytes [MAX_PATTERN],
   output logic      [CountWidth-1:0]    emit_count,
   output srf_load_type                  emit_ctl
);

   logic [CharWidth-1:0]  window_ff [MAX_PATTERN];
   logic [CharWidth-1:0]  window_in [MAX_PATTERN];
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic [CharWidth-1:0]  ext [MAX_PATTERN];
   logic [CharWidth-1:0]  aligned;
   logic [CountWidth-1:0] act_len;
   logic [CountWidth-1:0] fill;
   logic [CountWidth-1:0] drop;
   logic [CountWidth-1:0] emit;
   logic                  full;
   logic                  mismatch;
   logic                  matched;

   always_comb begin
      // clamp the configured length to the window depth
      if (pattern_length > PatLenWidth'(MAX_PATTERN)) begin
         act_len = CountWidth'(MAX_PATTERN);
      end else begin
         act_len = pattern_length[CountWidth-1:0];
      end

      // window with the new byte appended
      for (int j = 0; j < MAX_PATTERN; j++) begin
         ext[j] = (CountWidth'(j) == count_ff) ? char_in : window_ff[j];
      end
      fill = count_ff + CountWidth'(1);

      // bytes beyond the current length leave first
      drop = (fill > act_len) ? fill - act_len : '0;
      full = (act_len != '0) && (fill >= act_len);

      mismatch = 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         aligned = '0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j == int'(drop) + i) begin
               aligned = ext[j];
            end
         end
         if (i < int'(act_len) && aligned != pattern_chars[CharWidth*i +: CharWidth]) begin
            mismatch = 1'b1;
         end
      end
      matched = full && !mismatch;

      // kept bytes always form a prefix of the window
      priority if (matched) begin
         emit = drop;
      end else if (last_in) begin
         emit = fill;
      end else if (full) begin
         emit = drop + CountWidth'(1);
      end else begin
         emit = drop;
      end

      for (int j = 0; j < MAX_PATTERN; j++) begin
         window_in[j] = '0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (j + int'(emit) == k) begin
               window_in[j] = ext[k];
            end
         end
      end
      count_in = (matched || last_in) ? '0 : fill - emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   assign emit_bytes      = ext;
   assign emit_count      = emit;
   assign emit_ctl.load   = accept;
   assign emit_ctl.last   = last_in;
   assign emit_ctl.marker = last_in && (emit == '0);

endmodule

`default_nettype wire

// ===== design/srf_out_buf.sv =====
`default_nettype none

module srf_out_buf import srf_pkg::*; #(
   parameter  int MAX_PATTERN = 8,
   localparam int CountWidth  = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CharWidth-1:0]  load_bytes [MAX_PATTERN],
   input  wire logic [CountWidth-1:0] load_count,
   input  wire srf_load_type          load_ctl,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [CharWidth-1:0]  char_out,
   output logic                       char_valid,
   output logic                       last_out
);

   logic [CharWidth-1:0]  buf_ff [MAX_PATTERN];
   logic [CharWidth-1:0]  buf_in [MAX_PATTERN];
   logic [CountWidth-1:0] rem_ff;
   logic [CountWidth-1:0] rem_in;
   logic                  marker_ff;
   logic                  marker_in;
   logic                  last_ff;
   logic                  last_in;
   logic                  pop;

   assign pop      = rsp_valid && rsp_ready;
   assign can_load = (rem_ff == '0) || ((rem_ff == CountWidth'(1)) && rsp_ready);

   always_comb begin
      buf_in    = buf_ff;
      rem_in    = rem_ff;
      marker_in = marker_ff;
      last_in   = last_ff;
      priority if (load_ctl.load) begin
         buf_in    = load_bytes;
         rem_in    = load_ctl.marker ? CountWidth'(1) : load_count;
         marker_in = load_ctl.marker;
         last_in   = load_ctl.last;
      end else if (pop) begin
         for (int j = 0; j < MAX_PATTERN - 1; j++) begin
            buf_in[j] = buf_ff[j+1];
         end
         rem_in = rem_ff - CountWidth'(1);
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         marker_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         marker_ff <= marker_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_valid  = rem_ff != '0;
   assign char_out   = marker_ff ? '0 : buf_ff[0];
   assign char_valid = !marker_ff;
   assign last_out   = last_ff && (rem_ff == CountWidth'(1));

endmodule

`default_nettype wire

// ===== sim/substring_removal_filter_test.sv =====
`timescale 1ns / 100ps

module substring_removal_filter_test;
   import srf_pkg::*;

   localparam int MaxPattern   = 8;
   localparam int RandomItems  = 200;
   localparam int StallLimit   = 2000;   // cycles with no transaction on any channel
   localparam int LongHold     = 300;    // receiver hold-off for the backpressure test
   localparam int SettleCycles = 4;      // margin for the block to settle after the last response
   localparam int MaxReports   = 10;

   // one expected response: kept byte, byte flag, end-of-text flag
   typedef struct packed {
      logic [CharWidth-1:0] byte_val;
      logic                 has_byte;
      logic                 is_last;
   } kept_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srf_req_if req_ch ();
   srf_rsp_if rsp_ch ();
   srf_csr_if csr_ch ();

   substring_removal_filter #(
      .MAX_PATTERN(MaxPattern)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // filter prediction: own copy of the registers and of the pending window
   // ---------------------------------------------------------------------
   logic [PatLenWidth-1:0]   cur_len;
   logic [PatCharsWidth-1:0] cur_chars;
   logic [CharWidth-1:0]     window_bytes [MaxPattern];
   int unsigned              window_fill;

   kept_byte_type kept_bytes_q [$];

   // run statistics
   int errors        = 0;
   int reports       = 0;
   int bytes_sent    = 0;
   int texts_ended   = 0;
   int rsp_checked   = 0;
   int end_markers   = 0;
   int csr_writes    = 0;

   // oldest pending byte leaves the window, the rest shift down
   function automatic logic [CharWidth-1:0] take_oldest();
      logic [CharWidth-1:0] b;
      b = window_bytes[0];
      for (int i = 1; i < window_fill && i < MaxPattern; i++)
         window_bytes[i-1] = window_bytes[i];
      if (window_fill > 0)
         window_fill--;
      return b;
   endfunction

   function automatic bit window_is_pattern(input int unsigned len);
      for (int i = 0; i < len; i++)
         if (window_bytes[i] != cur_chars[8*i +: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   // one accepted text byte: work out the responses it releases
   function automatic void filter_text_byte(input logic [CharWidth-1:0] ch, input logic last);
      int unsigned   len;
      int            n;
      kept_byte_type step_out [8];
      len = (cur_len > MaxPattern) ? MaxPattern : cur_len;
      n = 0;
      if (window_fill > MaxPattern - 1)
         window_fill = MaxPattern - 1;
      window_bytes[window_fill] = ch;
      window_fill++;
      // window longer than the pattern (length shrunk, or no pattern at all)
      while (window_fill > len && n < 8) begin
         step_out[n].byte_val = take_oldest();
         step_out[n].has_byte = 1'b1;
         step_out[n].is_last  = 1'b0;
         n++;
      end
      // full window: drop it on a match, else release the oldest byte
      if (len > 0 && window_fill == len) begin
         if (window_is_pattern(len)) begin
            window_fill = 0;
         end else if (n < 8) begin
            step_out[n].byte_val = take_oldest();
            step_out[n].has_byte = 1'b1;
            step_out[n].is_last  = 1'b0;
            n++;
         end
      end
      // end of text: flush, then mark the final response
      if (last) begin
         while (window_fill > 0 && n < 8) begin
            step_out[n].byte_val = take_oldest();
            step_out[n].has_byte = 1'b1;
            step_out[n].is_last  = 1'b0;
            n++;
         end
         window_fill = 0;
         if (n > 0) begin
            step_out[n-1].is_last = 1'b1;
         end else begin
            // final byte completed a match, only a bare end marker is left
            step_out[0].byte_val = '0;
            step_out[0].has_byte = 1'b0;
            step_out[0].is_last  = 1'b1;
            n = 1;
         end
      end
      for (int i = 0; i < n; i++)
         kept_bytes_q.push_back(step_out[i]);
   endfunction

   function automatic void apply_csr_write(input logic [CsrIndexWidth-1:0] idx,
                                           input logic [CsrDataWidth-1:0] data);
      if (idx == RegPatternLength)
         cur_len = data[PatLenWidth-1:0];
      else if (idx == RegPatternChars)
         cur_chars = data;
   endfunction

   function automatic void check_response(input kept_byte_type got);
      kept_byte_type want;
      if (kept_bytes_q.size() == 0) begin
         errors++;
         if (reports < MaxReports)
            $display("%0t: unexpected response char=%h valid=%b last=%b", $realtime,
                     got.byte_val, got.has_byte, got.is_last);
         reports++;
      end else begin
         want = kept_bytes_q.pop_front();
         if (got !== want) begin
            errors++;
            if (reports < MaxReports)
               $display("%0t: mismatch exp char=%h valid=%b last=%b got char=%h valid=%b last=%b",
                        $realtime, want.byte_val, want.has_byte, want.is_last,
                        got.byte_val, got.has_byte, got.is_last);
            reports++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // monitor: config writes, accepted bytes and responses, in that order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      kept_byte_type got;
      if (reset) begin
         cur_len     = '0;
         cur_chars   = '0;
         window_fill = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            apply_csr_write(csr_ch.index, csr_ch.data);
            csr_writes++;
         end
         if (req_ch.valid && req_ch.ready) begin
            filter_text_byte(req_ch.char_in, req_ch.last_in);
            bytes_sent++;
            if (req_ch.last_in)
               texts_ended++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.byte_val = rsp_ch.char_out;
            got.has_byte = rsp_ch.char_valid;
            got.is_last  = rsp_ch.last_out;
            check_response(got);
            rsp_checked++;
            if (!rsp_ch.char_valid)
               end_markers++;
         end
      end
   end

   // watchdog: ends the run when the channels stay quiet too long
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((csr_ch.valid && csr_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d responses pending",
                     $realtime, quiet_cycles, kept_bytes_q.size());
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: rotating stall patterns plus a long hold-off on request
   // ---------------------------------------------------------------------
   logic long_hold_req = 1'b0;
   int   hold_left     = 0;
   int   rx_tick       = 0;
   int   rx_mode       = 0;

   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left = LongHold;
         long_hold_req = 1'b0;
      end
      rx_tick++;
      if (rx_tick % 64 == 0)
         rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         unique case (rx_mode)
            0: rsp_ch.ready <= 1'b1;                          // no stalls
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);   // light stalls
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
            default: rsp_ch.ready <= (rx_tick % 5 != 0);      // periodic
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------
   int burst_left = 0;
   bit gaps_on    = 1'b1;

   // returns right after the accepting edge, valid still high
   task automatic send_text_byte(input logic [CharWidth-1:0] ch, input logic last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= ch;
      req_ch.last_in <= last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // sender pauses until every expected response is back, then lets the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (kept_bytes_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_pattern(input logic [PatLenWidth-1:0] len,
                              input logic [PatCharsWidth-1:0] chars);
      write_csr(RegPatternLength, CsrDataWidth'(len));
      write_csr(RegPatternChars, chars);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty pattern: bytes pass through, extreme byte values
   task automatic test_passthrough();
      wait_idle();
      set_pattern(4'd0, 64'h0);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b1);
   endtask

   // two-byte pattern, the final byte completes a match so only an end marker remains
   task automatic test_pattern_removal();
      wait_idle();
      set_pattern(4'd2, 64'h6261);   // "ab"
      send_text_byte("x", 1'b0);
      send_text_byte("a", 1'b0);
      send_text_byte("b", 1'b0);
      send_text_byte("a", 1'b0);
      send_text_byte("b", 1'b1);
   endtask

   // length above the maximum counts as eight, pattern of extreme bytes
   task automatic test_long_pattern();
      logic [PatCharsWidth-1:0] pat;
      pat = 64'h00FF_00FF_A55A_FF00;
      wait_idle();
      set_pattern(4'd15, pat);
      send_text_byte(8'h00, 1'b0);
      for (int i = 0; i < MaxPattern; i++)
         send_text_byte(pat[8*i +: 8], i == MaxPattern - 1);
   endtask

   // length shrunk while bytes are pending: the surplus leaves at once
   task automatic test_length_shrink();
      wait_idle();
      set_pattern(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
      send_text_byte(8'h11, 1'b0);
      send_text_byte(8'h22, 1'b0);
      send_text_byte(8'h33, 1'b0);
      wait_idle();
      set_pattern(4'd1, 64'h44);
      send_text_byte(8'h44, 1'b1);
   endtask

   // pattern bytes changed mid-text, the pending byte and the next one match the new pattern
   task automatic test_pattern_swap();
      wait_idle();
      set_pattern(4'd2, 64'h6261);   // "ab"
      send_text_byte("a", 1'b0);
      wait_idle();
      write_csr(RegPatternChars, 64'h6361);   // "ac"
      send_text_byte("c", 1'b1);
   endtask

   // receiver holds off while the sender keeps offering, block must stall its input
   task automatic test_backpressure();
      wait_idle();
      set_pattern(4'd0, 64'h0);
      gaps_on = 1'b0;
      long_hold_req = 1'b1;
      for (int i = 0; i < 40; i++)
         send_text_byte(8'($urandom), i == 39);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   // random texts built mostly from pattern copies and pattern bytes
   task automatic test_random_texts();
      int                       sent;
      int                       chunk;
      int                       k;
      int                       sel;
      int unsigned              eff_len;
      logic [PatLenWidth-1:0]   len;
      logic [PatCharsWidth-1:0] chars;
      logic [CsrDataWidth-1:0]  len_word;
      logic [CharWidth-1:0]     ch;
      sent = 0;
      while (sent < RandomItems) begin
         wait_idle();
         sel = $urandom_range(0, 9);
         if (sel == 0)
            len = 4'd0;
         else if (sel == 1)
            len = 4'd8;
         else if (sel == 2)
            len = 4'($urandom_range(9, 15));
         else
            len = 4'($urandom_range(1, 4));
         eff_len = (len > MaxPattern) ? MaxPattern : len;
         if ($urandom_range(0, 4) == 0) begin
            chars = {$urandom, $urandom};
         end else begin
            for (int i = 0; i < MaxPattern; i++)
               chars[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                              : 8'("a" + $urandom_range(0, 2));
         end
         // upper bits of the length word are don't-care
         len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
         len_word[PatLenWidth-1:0] = len;
         if ($urandom_range(0, 1)) begin
            write_csr(RegPatternLength, len_word);
            write_csr(RegPatternChars, chars);
         end else begin
            write_csr(RegPatternChars, chars);
            write_csr(RegPatternLength, len_word);
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         chunk = $urandom_range(20, 50);
         k = 0;
         while (k < chunk) begin
            sel = $urandom_range(0, 9);
            if (sel < 4 && eff_len > 0) begin
               // whole pattern copy, occasionally with a random final byte
               for (int j = 0; j < eff_len; j++) begin
                  if (sel == 0 && j == eff_len - 1 && $urandom_range(0, 1))
                     ch = 8'($urandom);
                  else
                     ch = chars[8*j +: 8];
                  send_text_byte(ch, $urandom_range(0, 11) == 0);
                  k++;
               end
            end else if (sel < 8 && eff_len > 0) begin
               send_text_byte(chars[8*$urandom_range(0, eff_len-1) +: 8],
                              $urandom_range(0, 11) == 0);
               k++;
            end else begin
               send_text_byte(8'($urandom), $urandom_range(0, 11) == 0);
               k++;
            end
            if ($urandom_range(0, 39) == 0)
               wait_idle();
         end
         sent += k;
      end
      // close the last text
      send_text_byte(8'($urandom), 1'b1);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.char_in = '0;
      req_ch.last_in = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      rsp_ch.ready   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_pattern_removal();
      test_long_pattern();
      test_length_shrink();
      test_pattern_swap();
      test_backpressure();
      test_random_texts();

      wait_idle();
      repeat (8) @(posedge clock);
      if (kept_bytes_q.size() != 0) begin
         errors += kept_bytes_q.size();
         $display("%0d expected responses never arrived", kept_bytes_q.size());
      end
      $display("covered %0d text bytes in %0d texts, %0d config writes", bytes_sent,
               texts_ended, csr_writes);
      $display("checked %0d responses (%0d bare end markers), %0d errors", rsp_checked,
               end_markers, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
